// ----- sv/scra_pkg.sv -----
// ----------------------------------------------------------------------------
// scra_pkg
// Shared types, constants and bit functions of the column reorder core.
// ----------------------------------------------------------------------------
`default_nettype none

package scra_pkg;

   localparam int unsigned ROW_W   = 64;
   localparam int unsigned COL_W   = 6;
   localparam int unsigned LINK_W  = 3;
   localparam int unsigned SUM_W   = 9;
   localparam int unsigned POP_W   = 7;
   localparam int unsigned COUNT_W = 14;

   typedef logic [ROW_W-1:0]  row_type;
   typedef logic [LINK_W-1:0] link_type;
   typedef logic [SUM_W-1:0]  sum_type;
   typedef logic [POP_W-1:0]  pop_type;

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_LANE   = 7'b0000010,
      ST_SUM1   = 7'b0000100,
      ST_SUM2   = 7'b0001000,
      ST_DECIDE = 7'b0010000,
      ST_RUN    = 7'b0100000,
      ST_EMIT   = 7'b1000000
   } state_type;

   function automatic pop_type pop_count(input row_type v);
      pop_type n;
      n = '0;
      for (int b = 0; b < ROW_W; b++) begin
         n = n + pop_type'(v[b]);
      end
      return n;
   endfunction

   // Adjacencies of the one column selected by mask m: bit c with c+1 and c-1.
   function automatic logic [1:0] col_links(input row_type row, input row_type m);
      row_type adj;
      adj = row & (row >> 1);
      return {1'b0, |(adj & m)} + {1'b0, |(adj & (m >> 1))};
   endfunction

   function automatic row_type swap_cols(input row_type row, input row_type mi,
                                         input row_type mj);
      logic bi;
      logic bj;
      bi = |(row & mi);
      bj = |(row & mj);
      return (bi != bj) ? (row ^ (mi | mj)) : row;
   endfunction

   // Bit plane b of the identity column map: bit c holds bit b of c.
   function automatic row_type ident_plane(input int unsigned b);
      row_type p;
      for (int c = 0; c < ROW_W; c++) begin
         p[c] = ((c >> b) & 1) != 0;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ----- sv/scra_req_if.sv -----
// ----------------------------------------------------------------------------
// scra_req_if
// Row input channel: valid, ready and one matrix row.
// ----------------------------------------------------------------------------
`default_nettype none

interface scra_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] row_bits;

   modport source (output valid, output row_bits, input ready);
   modport sink   (input valid, input row_bits, output ready);
endinterface

`default_nettype wire

// ----- sv/scra_rsp_if.sv -----
// ----------------------------------------------------------------------------
// scra_rsp_if
// Result channel: valid, ready and one reordered row with its counts.
// ----------------------------------------------------------------------------
`default_nettype none

interface scra_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] out_row_bits;
   logic [5:0]  source_column;
   logic [13:0] dense_count;
   logic [13:0] run_count;
   logic        last_result;

   modport source (output valid, output out_row_bits, output source_column,
                   output dense_count, output run_count, output last_result,
                   input ready);
   modport sink   (input valid, input out_row_bits, input source_column,
                   input dense_count, input run_count, input last_result,
                   output ready);
endinterface

`default_nettype wire

// ----- sv/scra_lane.sv -----
// ----------------------------------------------------------------------------
// scra_lane
// One row lane: adjacency sums of a column pair before and after a swap.
// ----------------------------------------------------------------------------
`default_nettype none

module scra_lane
   import scra_pkg::*;
(
   input  wire logic     clock,
   input  wire row_type  row,
   input  wire row_type  mask_i,
   input  wire row_type  mask_j,
   output link_type      before_ff,
   output link_type      after_ff
);

   row_type  swapped;
   link_type before_in;
   link_type after_in;

   always_comb begin
      swapped   = swap_cols(row, mask_i, mask_j);
      before_in = link_type'(col_links(row, mask_i)) + link_type'(col_links(row, mask_j));
      after_in  = link_type'(col_links(swapped, mask_i))
                + link_type'(col_links(swapped, mask_j));
   end

   always_ff @(posedge clock) begin
      before_ff <= before_in;
      after_ff  <= after_in;
   end

endmodule

`default_nettype wire

// ----- sv/scra_merge.sv -----
// ----------------------------------------------------------------------------
// scra_merge
// Two-stage registered adder tree over the lane results.
// ----------------------------------------------------------------------------
`default_nettype none

module scra_merge
   import scra_pkg::*;
(
   input  wire logic     clock,
   input  wire link_type before_lane [64],
   input  wire link_type after_lane  [64],
   output sum_type       before_ff,
   output sum_type       after_ff
);

   logic [5:0] grp_before_ff [8];
   logic [5:0] grp_after_ff  [8];
   logic [5:0] grp_before_in [8];
   logic [5:0] grp_after_in  [8];
   sum_type    before_in;
   sum_type    after_in;

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         grp_before_in[g] = '0;
         grp_after_in[g]  = '0;
         for (int k = 0; k < 8; k++) begin
            grp_before_in[g] = grp_before_in[g] + 6'(before_lane[g*8+k]);
            grp_after_in[g]  = grp_after_in[g] + 6'(after_lane[g*8+k]);
         end
      end
      before_in = '0;
      after_in  = '0;
      for (int g = 0; g < 8; g++) begin
         before_in = before_in + sum_type'(grp_before_ff[g]);
         after_in  = after_in + sum_type'(grp_after_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      grp_before_ff <= grp_before_in;
      grp_after_ff  <= grp_after_in;
      before_ff     <= before_in;
      after_ff      <= after_in;
   end

endmodule

`default_nettype wire

// ----- sv/sparse_column_adjacency_reorder_core.sv -----
// ----------------------------------------------------------------------------
// sparse_column_adjacency_reorder_core
// Loads a square zero/nonzero matrix row by row, greedily swaps column pairs
// to keep horizontal adjacency, and emits the reordered rows with counts.
// ----------------------------------------------------------------------------
//   channel   dir  payload                                        accepted when
//   req_chan  in   row_bits                                       valid && ready
//   rsp_chan  out  out_row_bits, source_column, dense_count,      valid && ready
//                  run_count, last_result
//
// Rows load one per cycle while valid is held. After the last row, each
// column pair passes lane evaluation, two adder tree stages and a decision,
// N*(N-1)/2 pairs in all; then run counting over N rows, N result transactions.
// Reset is synchronous and clears the control state and the column map.
// A stalled result holds; no row is taken until all results are delivered.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_column_adjacency_reorder_core
   import scra_pkg::*;
#(
   parameter int unsigned MATRIX_SIZE = 64
)(
   input  wire logic   clock,
   input  wire logic   reset,
   scra_req_if.sink    req_chan,
   scra_rsp_if.source  rsp_chan
);

   localparam row_type        ROW_MASK = {ROW_W{1'b1}} >> (ROW_W - MATRIX_SIZE);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(MATRIX_SIZE - 1);
   localparam logic [COL_W-1:0] LAST_I   = COL_W'(MATRIX_SIZE - 2);
   localparam logic [6:0]       LAST_ROW = 7'(MATRIX_SIZE - 1);

   state_type        state_ff, state_in;
   row_type          row_ff   [MATRIX_SIZE];
   row_type          row_in   [MATRIX_SIZE];
   row_type          plane_ff [COL_W];
   row_type          plane_in [COL_W];
   logic [6:0]       loaded_ff, loaded_in;
   logic [COL_W-1:0] col_i_ff, col_i_in;
   logic [COL_W-1:0] col_j_ff, col_j_in;
   logic [COL_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] dense_ff, dense_in;
   logic [COUNT_W-2:0] run_ff, run_in;

   row_type  mask_i;
   row_type  mask_j;
   row_type  new_row;
   row_type  head;
   pop_type  new_pop;
   link_type before_lane [64];
   link_type after_lane  [64];
   sum_type  before_sum;
   sum_type  after_sum;
   logic     keep;

   assign mask_i = row_type'(1) << col_i_ff;
   assign mask_j = row_type'(1) << col_j_ff;

   genvar r;
   generate
      for (r = 0; r < 64; r++) begin : g_lane
         if (r < MATRIX_SIZE) begin : g_on
            scra_lane u_lane (
               .clock     (clock),
               .row       (row_ff[r]),
               .mask_i    (mask_i),
               .mask_j    (mask_j),
               .before_ff (before_lane[r]),
               .after_ff  (after_lane[r])
            );
         end else begin : g_off
            assign before_lane[r] = '0;
            assign after_lane[r]  = '0;
         end
      end
   endgenerate

   scra_merge u_merge (
      .clock       (clock),
      .before_lane (before_lane),
      .after_lane  (after_lane),
      .before_ff   (before_sum),
      .after_ff    (after_sum)
   );

   assign keep    = !(after_sum < before_sum);
   assign new_row = req_chan.row_bits & ROW_MASK;
   assign new_pop = pop_count(new_row);
   assign head    = row_ff[0];

   assign req_chan.ready = (state_ff == ST_LOAD);

   always_comb begin
      rsp_chan.valid        = (state_ff == ST_EMIT);
      rsp_chan.out_row_bits = head;
      for (int b = 0; b < COL_W; b++) begin
         rsp_chan.source_column[b] = plane_ff[b][0];
      end
      rsp_chan.dense_count  = dense_ff;
      rsp_chan.run_count    = {run_ff, 1'b0};
      rsp_chan.last_result  = (cnt_ff == LAST_COL);
   end

   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      plane_in  = plane_ff;
      loaded_in = loaded_ff;
      col_i_in  = col_i_ff;
      col_j_in  = col_j_ff;
      cnt_in    = cnt_ff;
      dense_in  = dense_ff;
      run_in    = run_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               // Rows shift down so that the first row loaded ends in lane 0.
               for (int k = 0; k < MATRIX_SIZE - 1; k++) begin
                  row_in[k] = row_ff[k+1];
               end
               row_in[MATRIX_SIZE-1] = new_row;
               dense_in  = dense_ff + COUNT_W'(new_pop) + COUNT_W'({new_pop, 1'b0});
               loaded_in = loaded_ff + 7'd1;
               if (loaded_ff == LAST_ROW) begin
                  loaded_in = '0;
                  col_i_in  = '0;
                  col_j_in  = COL_W'(1);
                  state_in  = ST_LANE;
               end
            end
         end
         ST_LANE:  state_in = ST_SUM1;
         ST_SUM1:  state_in = ST_SUM2;
         ST_SUM2:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (keep) begin
               for (int k = 0; k < MATRIX_SIZE; k++) begin
                  row_in[k] = swap_cols(row_ff[k], mask_i, mask_j);
               end
               for (int b = 0; b < COL_W; b++) begin
                  plane_in[b] = swap_cols(plane_ff[b], mask_i, mask_j);
               end
            end
            state_in = ST_LANE;
            if (col_j_ff == LAST_COL) begin
               if (col_i_ff == LAST_I) begin
                  cnt_in   = '0;
                  run_in   = '0;
                  state_in = ST_RUN;
               end else begin
                  col_i_in = col_i_ff + COL_W'(1);
                  col_j_in = col_i_ff + COL_W'(2);
               end
            end else begin
               col_j_in = col_j_ff + COL_W'(1);
            end
         end
         ST_RUN: begin
            // Rotate the rows once through lane 0, adding nonzeros and run starts.
            run_in = run_ff + (COUNT_W-1)'(pop_count(head))
                   + (COUNT_W-1)'(pop_count(head & ~(head << 1)));
            for (int k = 0; k < MATRIX_SIZE - 1; k++) begin
               row_in[k] = row_ff[k+1];
            end
            row_in[MATRIX_SIZE-1] = head;
            cnt_in = cnt_ff + COL_W'(1);
            if (cnt_ff == LAST_COL) begin
               cnt_in   = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_chan.ready) begin
               for (int k = 0; k < MATRIX_SIZE - 1; k++) begin
                  row_in[k] = row_ff[k+1];
               end
               row_in[MATRIX_SIZE-1] = head;
               for (int b = 0; b < COL_W; b++) begin
                  plane_in[b] = plane_ff[b] >> 1;
               end
               cnt_in = cnt_ff + COL_W'(1);
               if (cnt_ff == LAST_COL) begin
                  for (int b = 0; b < COL_W; b++) begin
                     plane_in[b] = ident_plane(b);
                  end
                  cnt_in   = '0;
                  dense_in = '0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      col_i_ff <= col_i_in;
      col_j_ff <= col_j_in;
      run_ff   <= run_in;
      if (reset) begin
         state_ff  <= ST_LOAD;
         loaded_ff <= '0;
         cnt_ff    <= '0;
         dense_ff  <= '0;
         for (int b = 0; b < COL_W; b++) begin
            plane_ff[b] <= ident_plane(b);
         end
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         cnt_ff    <= cnt_in;
         dense_ff  <= dense_in;
         plane_ff  <= plane_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/sparse_column_adjacency_reorder_core_test.sv -----
// ----------------------------------------------------------------------------
// sparse_column_adjacency_reorder_core_test
// Loads whole matrices of directed and random rows into the column reorder
// core, predicts the greedy column swaps and the counts per matrix, and checks
// every reordered row with its source column, counts and last flag against the prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sparse_column_adjacency_reorder_core_test
   import scra_pkg::*;
();

   localparam int N      = 64;
   localparam int EXP_SZ = 128;

   typedef struct {
      row_type          out_row_bits;
      logic [COL_W-1:0] source_column;
      logic [13:0]      dense_count;
      logic [13:0]      run_count;
      logic             last_result;
   } reordered_row_type;

   logic clock;
   logic reset;
   scra_req_if req_chan ();
   scra_rsp_if rsp_chan ();

   sparse_column_adjacency_reorder_core #(.MATRIX_SIZE(N)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   row_type           grid [N];
   logic [COL_W-1:0]  origin [N];
   int                rows_in;
   logic [13:0]       dense_sum;
   reordered_row_type expected_rows [EXP_SZ];
   int                exp_wr;
   int                exp_rd;
   int                error_count;
   bit                steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int column_adjacency(input int c);
      int t;
      t = 0;
      for (int r = 0; r < N; r++) begin
         if (grid[r][c]) begin
            if (c + 1 < N && grid[r][c+1]) t++;
            if (c > 0 && grid[r][c-1]) t++;
         end
      end
      return t;
   endfunction

   function automatic void exchange_columns(input int i, input int j);
      logic b;
      for (int r = 0; r < N; r++) begin
         if (grid[r][i] != grid[r][j]) begin
            b = grid[r][i];
            grid[r][i] = grid[r][j];
            grid[r][j] = b;
         end
      end
   endfunction

   function automatic void reset_matrix();
      for (int c = 0; c < N; c++) origin[c] = COL_W'(c);
      rows_in   = 0;
      dense_sum = '0;
   endfunction

   // Takes one accepted row; on the last row of a matrix it runs the greedy
   // pass and queues all reordered rows.
   function automatic void predict_row(input row_type row);
      int                pre, post, runs;
      row_type           starts;
      logic [COL_W-1:0]  t;
      reordered_row_type e;
      grid[rows_in] = row;
      dense_sum     = dense_sum + 14'(3 * $countones(row));
      rows_in++;
      if (rows_in < N) return;
      for (int i = 0; i < N; i++) begin
         for (int j = i + 1; j < N; j++) begin
            pre = column_adjacency(j) + column_adjacency(i);
            exchange_columns(i, j);
            post = column_adjacency(j) + column_adjacency(i);
            if (post < pre) begin
               exchange_columns(i, j);
            end else begin
               t = origin[i];
               origin[i] = origin[j];
               origin[j] = t;
            end
         end
      end
      runs = 0;
      for (int r = 0; r < N; r++) begin
         starts = grid[r] & ~(grid[r] << 1);
         runs   = runs + 2 * $countones(grid[r]) + 2 * $countones(starts);
      end
      for (int k = 0; k < N; k++) begin
         e.out_row_bits  = grid[k];
         e.source_column = origin[k];
         e.dense_count   = dense_sum;
         e.run_count     = 14'(runs);
         e.last_result   = (k == N - 1);
         expected_rows[exp_wr % EXP_SZ] = e;
         exp_wr++;
      end
      reset_matrix();
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   task automatic send_row(input row_type row);
      int gap;
      gap = steady ? 0 : $urandom_range(10);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.row_bits <= row;
      do @(posedge clock); while (!req_chan.ready);
      predict_row(row);
   endtask

   function automatic row_type random_row(input int pct);
      row_type v;
      for (int b = 0; b < N; b++) v[b] = ($urandom_range(99) < pct);
      return v;
   endfunction

   function automatic row_type band_row();
      int lo, len;
      lo  = $urandom_range(N - 1);
      len = $urandom_range(12, 1);
      return (row_type'((64'd1 << len) - 1)) << lo;
   endfunction

   task automatic test_directed_rows();
      row_type picks [12];
      picks = '{64'd0, {64{1'b1}}, {32{2'b10}}, {32{2'b01}}, 64'd1, 64'd1 << 63,
                64'hC000_0000_0000_0003, 64'hFFFF_0000_0000_FFFF, 64'h0000_0001_8000_0000,
                64'hF0F0_F0F0_F0F0_F0F0, 64'd3, 64'h8000_0000_0000_0001};
      foreach (picks[p]) send_row(picks[p]);
      for (int r = 12; r < N; r++) send_row(random_row(30));
   endtask

   task automatic test_sparse_matrix();
      for (int r = 0; r < N; r++) send_row(random_row($urandom_range(15)));
   endtask

   task automatic test_dense_matrix();
      steady = 1'b1;
      for (int r = 0; r < N; r++) send_row(random_row($urandom_range(100, 60)));
      steady = 1'b0;
   endtask

   task automatic test_banded_matrix();
      for (int r = 0; r < N; r++)
         send_row(($urandom_range(3) == 0) ? random_row(50) : band_row());
   endtask

   // Result side stall: a random hold-off before each transaction, none while steady is set.
   initial begin
      int gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = steady ? 0 : $urandom_range(10);
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (exp_rd == exp_wr) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            reordered_row_type e;
            e = expected_rows[exp_rd % EXP_SZ];
            exp_rd++;
            if (rsp_chan.out_row_bits !== e.out_row_bits)
               report_mismatch($sformatf("out_row_bits %h, expected %h",
                               rsp_chan.out_row_bits, e.out_row_bits));
            if (rsp_chan.source_column !== e.source_column)
               report_mismatch($sformatf("source_column %0d, expected %0d",
                               rsp_chan.source_column, e.source_column));
            if (rsp_chan.dense_count !== e.dense_count)
               report_mismatch($sformatf("dense_count %0d, expected %0d",
                               rsp_chan.dense_count, e.dense_count));
            if (rsp_chan.run_count !== e.run_count)
               report_mismatch($sformatf("run_count %0d, expected %0d",
                               rsp_chan.run_count, e.run_count));
            if (rsp_chan.last_result !== e.last_result)
               report_mismatch($sformatf("last_result %b, expected %b",
                               rsp_chan.last_result, e.last_result));
         end
      end
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      error_count = 0;
      exp_wr      = 0;
      exp_rd      = 0;
      steady      = 1'b0;
      grid        = '{default: '0};
      reset_matrix();
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.row_bits <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_rows();
      test_sparse_matrix();
      test_dense_matrix();
      test_banded_matrix();
      test_sparse_matrix();
      req_chan.valid <= 1'b0;
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
